>>> hw/rtl/shbm_pkg.sv
// ----------------------------------------------------------------------------
// shbm_pkg
// Shared widths, defaults and command codes of the histogram bin merge core.
// ----------------------------------------------------------------------------
package shbm_pkg;
   localparam int NumBinsDefault = 32;
   localparam int ValW  = 64;
   localparam int CntW  = 32;
   localparam int IdxW  = 5;
   localparam int SumW  = CntW + 1;
   localparam int ProdW = ValW + SumW - 1;
   localparam int NumW  = ProdW + 1;

   typedef enum logic {
      ACT_ADD  = 1'b0,
      ACT_READ = 1'b1
   } action_type;
endpackage

>>> hw/rtl/shbm_divider.sv
// ----------------------------------------------------------------------------
// shbm_divider
// Restoring divider, one quotient bit per cycle, for the weighted mean.
// ----------------------------------------------------------------------------
module shbm_divider import shbm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [NumW-1:0] numer,
   input  logic [SumW-1:0] denom,
   output logic            done,
   output logic [ValW-1:0] quot
);
   localparam int StepW = $clog2(NumW + 1);

   logic [NumW-1:0]  num_ff, num_in;
   logic [SumW:0]    rem_ff, rem_in;
   logic [SumW-1:0]  den_ff, den_in;
   logic [NumW-1:0]  q_ff, q_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [SumW+1:0]  trial;
   logic [SumW+1:0]  shifted;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; q_in = q_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      shifted = {rem_ff, num_ff[NumW-1]};
      trial = shifted - {2'b00, den_ff};
      if (go) begin
         num_in = numer; den_in = denom; rem_in = '0; q_in = '0;
         step_in = StepW'(NumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (!trial[SumW+1]) begin
            rem_in = trial[SumW:0];
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = shifted[SumW:0];
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff[ValW-1:0];
endmodule

>>> hw/rtl/streaming_histogram_bin_merge_core.sv
// ----------------------------------------------------------------------------
// streaming_histogram_bin_merge_core
// Sorted bins in two memories; add inserts a sample and merges the closest pair.
//
// channel  | ports                                   | handshake
// request  | req_action, req_sample_value, req_bin_index | start & !busy
// response | rsp_bin_value, rsp_bin_count, rsp_all_empty | rsp_valid, 1 cycle
//
// read: a memory read, then the response. add: memory scans and multiply steps,
// plus the divider when the merged counts are nonzero.
// bins clear by a sweep over all NUM_BINS bins after reset, busy held high.
// the receiver cannot stall; each response shows for one cycle.
// ----------------------------------------------------------------------------
module streaming_histogram_bin_merge_core import shbm_pkg::*; #(
   parameter int NUM_BINS = NumBinsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic            req_action,
   input  logic [ValW-1:0] req_sample_value,
   input  logic [IdxW-1:0] req_bin_index,
   output logic            rsp_valid,
   output logic [ValW-1:0] rsp_bin_value,
   output logic [CntW-1:0] rsp_bin_count,
   output logic            rsp_all_empty
);
   localparam int AW = $clog2(NUM_BINS);
   localparam int PW = $clog2(NUM_BINS + 2);
   localparam int EW = $clog2(NUM_BINS + 1);
   localparam int HW = ValW / 2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_SCAN, S_REWR, S_MRD1, S_MRD2, S_MUL,
      S_DIV, S_MWR, S_SHIFT, S_RESP
   } state_type;

   // bin memories, one write and one read port each, registered read
   logic [ValW-1:0] val_mem [NUM_BINS];
   logic [CntW-1:0] cnt_mem [NUM_BINS];
   logic [ValW-1:0] val_rd;
   logic [CntW-1:0] cnt_rd;
   logic            we;
   logic [AW-1:0]   raddr, waddr;
   logic [ValW-1:0] wval;
   logic [CntW-1:0] wcnt;

   always_ff @(posedge clock) begin
      if (we) begin
         val_mem[waddr] <= wval;
         cnt_mem[waddr] <= wcnt;
      end
      val_rd <= val_mem[raddr];
      cnt_rd <= cnt_mem[raddr];
   end

   state_type       state_ff, state_in;
   logic [PW-1:0]   i_ff, i_in;          // scan index into the merged sequence
   logic            ins_ff, ins_in;      // sample already placed
   logic [ValW-1:0] smp_ff, smp_in;
   logic [ValW-1:0] prev_ff, prev_in;
   logic [ValW-1:0] gap_ff, gap_in;
   logic [PW-1:0]   best_ff, best_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [ValW-1:0] v0_ff, v0_in;
   logic [CntW-1:0] c0_ff, c0_in;
   logic [ValW-1:0] v1_ff, v1_in;
   logic [CntW-1:0] c1_ff, c1_in;
   logic [ProdW-1:0] p0_ff, p0_in, p1_ff, p1_in;
   logic [ValW-1:0] mean_ff, mean_in;
   logic [EW-1:0]   nz_ff, nz_in;        // count of nonzero bins
   logic [ValW-1:0] ov_ff, ov_in;
   logic [CntW-1:0] oc_ff, oc_in;
   logic            ovalid_ff, ovalid_in;
   logic [IdxW-1:0] ridx_ff, ridx_in;
   logic            sh_ff, sh_in;        // divider started, or the shift read primed

   logic            div_go, div_done;
   logic [ValW-1:0] div_q;
   logic [SumW-1:0] dsum;

   // one 32x32 multiplier, stepped over the halves of both products
   logic [HW-1:0]      mul_a;
   logic [CntW-1:0]    mul_b;
   logic [HW+CntW-1:0] mul_p;

   assign mul_p = {{CntW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};

   shbm_divider u_div (
      .clock(clock), .reset(reset), .go(div_go),
      .numer({1'b0, p0_ff} + {1'b0, p1_ff}), .denom(dsum),
      .done(div_done), .quot(div_q)
   );

   assign dsum = {1'b0, c0_ff} + {1'b0, c1_ff};

   // old-bin address feeding new bin j
   function automatic logic [PW-1:0] src_of(input logic [PW-1:0] j);
      logic [PW-1:0] k;
      k = (j < best_ff) ? j : j + 1'b1;
      if (j == best_ff) k = j;
      return (k > pos_ff) ? k - 1'b1 : k;
   endfunction

   // current element of the sorted sequence with the sample inserted
   logic [ValW-1:0] cur_v;
   logic            take_smp;
   logic            nz_new;

   always_comb begin
      state_in = state_ff; i_in = i_ff; ins_in = ins_ff; smp_in = smp_ff;
      prev_in = prev_ff; gap_in = gap_ff; best_in = best_ff; pos_in = pos_ff;
      v0_in = v0_ff; c0_in = c0_ff; v1_in = v1_ff; c1_in = c1_ff;
      p0_in = p0_ff; p1_in = p1_ff; mean_in = mean_ff; nz_in = nz_ff;
      ov_in = ov_ff; oc_in = oc_ff; ovalid_in = 1'b0;
      ridx_in = ridx_ff; sh_in = sh_ff;
      we = 1'b0; raddr = '0; waddr = '0; wval = '0; wcnt = '0; div_go = 1'b0;
      take_smp = 1'b0; cur_v = '0; nz_new = 1'b0;
      mul_a = '0; mul_b = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = i_ff[AW-1:0];
            i_in = i_ff + 1'b1;
            if (i_ff == PW'(NUM_BINS - 1)) begin
               state_in = S_IDLE; i_in = '0;
            end
         end
         S_IDLE: begin
            if (start) begin
               smp_in = req_sample_value; ridx_in = req_bin_index;
               i_in = '0; ins_in = 1'b0;
               gap_in = '1; best_in = '0;
               if (req_action == ACT_READ) begin
                  raddr = AW'(req_bin_index);
                  state_in = S_READ;
               end else begin
                  raddr = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_READ: begin
            ov_in = '0; oc_in = '0;
            if ({{(32-IdxW){1'b0}}, ridx_ff} < 32'(NUM_BINS)) begin
               ov_in = val_rd; oc_in = cnt_rd;
            end
            state_in = S_RESP;
         end
         S_SCAN: begin
            // val_rd holds old bin (i - ins); emit one merged-sequence element
            take_smp = !ins_ff && (i_ff == PW'(NUM_BINS) || val_rd > smp_ff);
            cur_v = take_smp ? smp_ff : val_rd;
            if (take_smp) begin
               ins_in = 1'b1; pos_in = i_ff;
            end
            if (i_ff != '0 && (cur_v - prev_ff) < gap_ff) begin
               gap_in = cur_v - prev_ff; best_in = i_ff - 1'b1;
            end
            if (i_ff == '0) gap_in = '1;
            prev_in = cur_v;
            raddr = take_smp ? AW'(i_ff - (ins_ff ? 1'b1 : 1'b0))
                             : AW'(i_ff + 1'b1 - (ins_ff ? 1'b1 : 1'b0));
            i_in = i_ff + 1'b1;
            if (i_ff == PW'(NUM_BINS)) begin
               state_in = S_MRD1;
               i_in = '0;
            end
         end
         S_MRD1: begin
            // fetch left member of best pair
            raddr = AW'(best_ff > pos_ff ? best_ff - 1'b1 : best_ff);
            state_in = S_MRD2;
         end
         S_MRD2: begin
            if (best_ff == pos_ff) begin
               v0_in = smp_ff; c0_in = CntW'(1);
            end else begin
               v0_in = val_rd; c0_in = cnt_rd;
            end
            raddr = AW'(best_ff + 1'b1 > pos_ff ? best_ff : best_ff + 1'b1);
            state_in = S_MUL;
            i_in = '0;
         end
         S_MUL: begin
            // products built from 32-bit halves over four steps
            if (i_ff == PW'(0)) begin
               if (best_ff + 1'b1 == pos_ff) begin
                  v1_in = smp_ff; c1_in = CntW'(1);
               end else begin
                  v1_in = val_rd; c1_in = cnt_rd;
               end
               p0_in = '0; p1_in = '0;
               i_in = PW'(1);
            end else if (i_ff == PW'(1)) begin
               mul_a = v0_ff[HW-1:0]; mul_b = c0_ff;
               p0_in = ProdW'(mul_p);
               i_in = PW'(2);
            end else if (i_ff == PW'(2)) begin
               mul_a = v0_ff[ValW-1:HW]; mul_b = c0_ff;
               p0_in = p0_ff + {mul_p, {HW{1'b0}}};
               i_in = PW'(3);
            end else if (i_ff == PW'(3)) begin
               mul_a = v1_ff[HW-1:0]; mul_b = c1_ff;
               p1_in = ProdW'(mul_p);
               i_in = PW'(4);
            end else begin
               mul_a = v1_ff[ValW-1:HW]; mul_b = c1_ff;
               p1_in = p1_ff + {mul_p, {HW{1'b0}}};
               if (dsum == '0) begin
                  mean_in = '0; state_in = S_MWR;
               end else begin
                  state_in = S_DIV; sh_in = 1'b0;
               end
            end
         end
         S_DIV: begin
            div_go = !sh_ff; sh_in = 1'b1;
            if (div_done) begin
               mean_in = div_q; state_in = S_MWR;
            end
         end
         S_MWR: begin
            // rebuild memory in place from bin 0 up; reads stay at or ahead of writes
            i_in = '0; nz_in = '0; ins_in = 1'b0; sh_in = 1'b0;
            raddr = '0; state_in = S_SHIFT;
         end
         S_SHIFT: begin
            // new bin j: j<best -> sample if j==pos, else old (j - (j>pos)); j==best -> merged;
            // j>best -> element j+1 of merged sequence
            waddr = i_ff[AW-1:0]; we = 1'b1;
            if (i_ff < best_ff) begin
               if (i_ff == pos_ff) begin
                  wval = smp_ff; wcnt = CntW'(1);
               end else begin
                  wval = val_rd; wcnt = cnt_rd;
               end
            end else if (i_ff == best_ff) begin
               wval = mean_ff;
               wcnt = dsum[SumW-1] ? '1 : dsum[CntW-1:0];
            end else begin
               if (i_ff + 1'b1 == pos_ff) begin
                  wval = smp_ff; wcnt = CntW'(1);
               end else begin
                  wval = val_rd; wcnt = cnt_rd;
               end
            end
            if (!sh_ff) begin
               // first cycle only primes the read of the source for bin 0
               we = 1'b0; sh_in = 1'b1;
               raddr = AW'(src_of(i_ff));
            end else begin
               nz_new = wval != '0 || wcnt != '0;
               nz_in = nz_ff + (nz_new ? 1'b1 : 1'b0);
               i_in = i_ff + 1'b1;
               raddr = AW'(src_of(i_ff + 1'b1));
               if (i_ff == PW'(NUM_BINS - 1)) begin
                  ov_in = '0; oc_in = '0; state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            ovalid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // nonzero-bin tally of the written bins, latched when an add's rewrite ends
   logic [EW-1:0] nzc_ff, nzc_in;
   always_comb begin
      nzc_in = nzc_ff;
      if (state_ff == S_SHIFT && state_in == S_RESP)
         nzc_in = nz_in;
   end

   always_ff @(posedge clock) begin
      ins_ff <= ins_in; smp_ff <= smp_in; prev_ff <= prev_in;
      gap_ff <= gap_in; best_ff <= best_in; pos_ff <= pos_in;
      v0_ff <= v0_in; c0_ff <= c0_in; v1_ff <= v1_in; c1_ff <= c1_in;
      p0_ff <= p0_in; p1_ff <= p1_in; mean_ff <= mean_in; nz_ff <= nz_in;
      ov_ff <= ov_in; oc_ff <= oc_in; ridx_ff <= ridx_in;
      sh_ff <= sh_in;
      if (reset) begin
         state_ff <= S_CLEAR; i_ff <= '0; ovalid_ff <= 1'b0; nzc_ff <= '0;
      end else begin
         state_ff <= state_in; i_ff <= i_in; ovalid_ff <= ovalid_in; nzc_ff <= nzc_in;
      end
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = ovalid_ff;
   assign rsp_bin_value = ov_ff;
   assign rsp_bin_count = oc_ff;
   assign rsp_all_empty = nzc_ff == '0;
endmodule
